/* sv/smd_pkg.sv */
// Package: shared types and constants for the SHA-1 digest core.
`timescale 1ns / 1ps
package smd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_beat_type;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hefcdab89;
   localparam logic [31:0] H2_INIT = 32'h98badcfe;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int          QUEUE_DEPTH = 2;

endpackage

/* sv/smd_queue.sv */
// Short queue between the front classifier and the back engine.
`timescale 1ns / 1ps
module smd_queue
   import smd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  req_beat_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output req_beat_type pop_data
);
   req_beat_type slot_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

/* sv/smd_engine.sv */
// Back engine: byte packing, padding, 80-round compression and digest output.
`timescale 1ns / 1ps
module smd_engine
   import smd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  req_beat_type cmd_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
   } state_type;

   state_type    state_ff;
   logic [31:0]  win_ff [16];
   logic [31:0]  h_ff [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [60:0]  bytes_ff;
   logic [5:0]   fill_ff;
   logic [6:0]   round_ff;
   logic         final_ff;   // current block is the last of the message
   logic         second_ff;  // another block follows this one
   logic [2:0]   idx_ff;
   logic         rv_ff;
   rsp_beat_type rd_ff;

   logic [3:0]  ri;
   logic [31:0] w_new, w_cur, f, k, t;
   logic [63:0] bit_len;

   assign ri = round_ff[3:0];
   assign w_new = win_ff[ri + 4'd13] ^ win_ff[ri + 4'd8] ^ win_ff[ri + 4'd2] ^ win_ff[ri];
   assign w_cur = (round_ff < 7'd16) ? win_ff[ri] : {w_new[30:0], w_new[31]};
   assign bit_len = {bytes_ff, 3'b000};

   always_comb begin
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_cur;
   end

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
         h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
         bytes_ff  <= '0;
         fill_ff   <= '0;
         round_ff  <= '0;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         idx_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  logic [5:0]  pos;
                  logic [60:0] cnt;
                  pos = fill_ff;
                  cnt = bytes_ff;
                  if (cmd_data.has_byte) begin
                     win_ff[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= cmd_data.data_byte;
                     cnt = bytes_ff + 61'd1;
                     pos = fill_ff + 6'd1;
                     bytes_ff <= cnt;
                     fill_ff  <= pos;
                  end
                  if (cmd_data.has_byte && pos == 6'd0) begin
                     // full block: compress, padding (if last) afterwards
                     final_ff  <= 1'b0;
                     second_ff <= cmd_data.is_last;
                     {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
                     round_ff <= '0;
                     state_ff <= ST_ROUND;
                  end else if (cmd_data.is_last) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               // 0x80 at the fill position, zeros after it; length in the top words if room
               for (int i = 0; i < 16; i++) begin
                  if (i >= 14 && fill_ff < 6'd56) begin
                     win_ff[i] <= (i == 14) ? bit_len[63:32] : bit_len[31:0];
                  end else begin
                     for (int j = 0; j < 4; j++) begin
                        if (6'(i * 4 + j) == fill_ff) win_ff[i][(3 - j) * 8 +: 8] <= PAD_BYTE;
                        else if (6'(i * 4 + j) > fill_ff) win_ff[i][(3 - j) * 8 +: 8] <= 8'h00;
                     end
                  end
               end
               if (fill_ff < 6'd56) begin
                  final_ff   <= 1'b1;
                  second_ff  <= 1'b0;
                  fill_ff    <= '0;
               end else begin
                  // fill kept non-zero: fold then starts the length-only block
                  final_ff  <= 1'b0;
                  second_ff <= 1'b1;
               end
               {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (round_ff >= 7'd16) win_ff[ri] <= w_cur;
               e_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff;
               a_ff <= t;
               if (round_ff == 7'd79) begin
                  round_ff <= '0;
                  state_ff <= ST_FOLD;
               end else begin
                  round_ff <= round_ff + 7'd1;
               end
            end
            ST_FOLD: begin
               h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               if (final_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_EMIT;
               end else if (second_ff) begin
                  second_ff <= 1'b0;
                  if (fill_ff == 6'd0) begin
                     // message ended on a block boundary: a full pad block follows
                     state_ff <= ST_PAD;
                  end else begin
                     // length-only block, working vars from the updated hash
                     for (int i = 0; i < 14; i++) win_ff[i] <= '0;
                     win_ff[14] <= bit_len[63:32];
                     win_ff[15] <= bit_len[31:0];
                     final_ff   <= 1'b1;
                     fill_ff    <= '0;
                     {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0] + a_ff, h_ff[1] + b_ff,
                                                        h_ff[2] + c_ff, h_ff[3] + d_ff,
                                                        h_ff[4] + e_ff};
                     round_ff   <= '0;
                     state_ff   <= ST_ROUND;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (!rv_ff || rsp_ready) begin
                  if (idx_ff == 3'd5) begin
                     if (rsp_ready || !rv_ff) rv_ff <= 1'b0;
                     h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
                     h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
                     bytes_ff <= '0;
                     fill_ff  <= '0;
                     final_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     rv_ff <= 1'b1;
                     rd_ff.digest_word <= h_ff[idx_ff];
                     rd_ff.word_index  <= idx_ff;
                     rd_ff.last_word   <= (idx_ff == 3'd4);
                     idx_ff <= idx_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff != ST_EMIT && rv_ff && rsp_ready) rv_ff <= 1'b0;
      end
   end
endmodule

/* sv/sha1_message_digest_core.sv */
// Top level: SHA-1 digest core, front queue plus compression engine.
// Flow: a byte beat is registered in the queue before the engine takes it, one beat while
// idle; the beat that completes a block holds the engine for the 80 rounds and the fold.
// Last beat: padding, rounds and fold, for a second block too when padding needs one;
// then the digest, registered, one beat per cycle while rsp_ready holds, 5 in all.
// The engine takes no new beats while it compresses, pads or emits; the queue holds them.
// Reset: synchronous, active high; chain hash returns to the SHA-1 initial values.
`timescale 1ns / 1ps
module sha1_message_digest_core
   import smd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);
   logic         q_valid, q_ready;
   req_beat_type q_data;

   // front: beats with neither a byte nor an end marker are dropped here
   logic keep;
   assign keep = req_data.has_byte || req_data.is_last;
   logic push_ready;
   assign req_ready = push_ready;

   smd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid && keep),
      .push_ready (push_ready),
      .push_data  (req_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   smd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

/* sv/smd_checker.sv */
// Port-level checker for the SHA-1 digest core, bound to the top level.
`timescale 1ns / 1ps
module smd_checker
   import smd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_beat_type rsp_data
);
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.word_index <= 3'd4)
      else $error("word index out of range");
   a_last_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd4)))
      else $error("last_word disagrees with index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");
endmodule

bind sha1_message_digest_core smd_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

/* tb/sha1_message_digest_core_tb.sv */
// Testbench for the SHA-1 digest core: directed table, random messages, scoreboard.
`timescale 1ns / 1ps
module sha1_message_digest_core_tb;
   import smd_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   sha1_message_digest_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The predictor keeps its own copy of the chaining hash and message state.
   logic [31:0]  hash_state [5];
   logic [31:0]  word_buf [16];
   logic [60:0]  byte_total;
   logic [5:0]   fill_pos;
   rsp_beat_type digest_queue [$];

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 13;
   int recv_idle_pct = 80;

   localparam int CYCLE_LIMIT = 400000;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      rol = (x << n) | (x >> (32 - n));
   endfunction

   task automatic clear_digest_state();
      hash_state[0] = H0_INIT; hash_state[1] = H1_INIT; hash_state[2] = H2_INIT;
      hash_state[3] = H3_INIT; hash_state[4] = H4_INIT;
      byte_total = '0;
      fill_pos = '0;
   endtask

   task automatic compress();
      logic [31:0] a, b, c, d, e, f, k, t, w;
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16) begin
            w = word_buf[(r + 13) & 15] ^ word_buf[(r + 8) & 15]
              ^ word_buf[(r + 2) & 15] ^ word_buf[r & 15];
            word_buf[r & 15] = rol(w, 1);
         end
         w = word_buf[r & 15];
         if (r < 20) begin
            f = (b & c) | (~b & d); k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         t = rol(a, 5) + f + e + k + w;
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
   endtask

   task automatic place_byte(input int pos, input logic [7:0] b);
      int sh;
      sh = (3 - (pos & 3)) * 8;
      word_buf[pos >> 2] = (word_buf[pos >> 2] & ~(32'hff << sh)) | (32'(b) << sh);
   endtask

   // Works out the digest words that one accepted beat causes, if any.
   task automatic predict_digest(input req_beat_type beat);
      logic [63:0]  bit_len;
      rsp_beat_type exp_word;
      int           pos;
      if (beat.has_byte) begin
         place_byte(fill_pos, beat.data_byte);
         byte_total += 1'b1;
         fill_pos += 1'b1;
         if (fill_pos == 0) compress();
      end
      if (beat.is_last) begin
         bit_len = {byte_total, 3'b000};
         pos = fill_pos;
         place_byte(pos, PAD_BYTE);
         for (int p = pos + 1; p < 64; p++) place_byte(p, 8'h00);
         if (pos >= 56) begin
            compress();
            for (int i = 0; i < 16; i++) word_buf[i] = '0;
         end
         word_buf[14] = bit_len[63:32];
         word_buf[15] = bit_len[31:0];
         compress();
         for (int i = 0; i < 5; i++) begin
            exp_word.digest_word = hash_state[i];
            exp_word.word_index = 3'(i);
            exp_word.last_word = (i == 4);
            digest_queue.push_back(exp_word);
         end
         clear_digest_state();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   // Result side: random stalls on ready, checks every accepted beat.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data.digest_word, 32'h0);
            end else begin
               rsp_beat_type want;
               want = digest_queue.pop_front();
               if (rsp_data.digest_word !== want.digest_word)
                  report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index !== want.word_index)
                  report_mismatch("word_index", 32'(rsp_data.word_index),
                                  32'(want.word_index));
               if (rsp_data.last_word !== want.last_word)
                  report_mismatch("last_word", 32'(rsp_data.last_word),
                                  32'(want.last_word));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Drives one beat; valid stays up until accepted, then predicts.
   task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, has_byte: has, is_last: last};
      do @(posedge clock); while (!req_ready);
      predict_digest('{data_byte: b, has_byte: has, is_last: last});
   endtask

   task automatic send_message(input int len, input logic last_has);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), last_has, 1'b1);
   endtask

   // Directed table: data_byte, has_byte, is_last.
   typedef struct {
      logic [7:0] b;
      logic       has;
      logic       last;
   } stim_row_type;

   stim_row_type directed [8] = '{
      '{8'h00, 1'b0, 1'b1},   // empty message
      '{8'h5a, 1'b0, 1'b0},   // no byte, no end: nothing happens
      '{8'h61, 1'b1, 1'b0},   // "abc"
      '{8'h62, 1'b1, 1'b0},
      '{8'h63, 1'b1, 1'b1},   // byte on the closing beat
      '{8'hff, 1'b1, 1'b0},
      '{8'h00, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b1}
   };

   // Well-known digests for the first two messages.
   localparam logic [31:0] EMPTY_DIGEST [5] = '{32'hda39a3ee, 32'h5e6b4b0d,
                                                32'h3255bfef, 32'h95601890, 32'hafd80709};
   localparam logic [31:0] ABC_DIGEST [5] = '{32'ha9993e36, 32'h4706816a,
                                              32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d};

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   initial begin
      int fixed_errs;
      clear_digest_state();
      for (int i = 0; i < 16; i++) word_buf[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_beat(directed[i].b, directed[i].has, directed[i].last);
         // known answers cross-check the predictor itself
         if (i == 0 || i == 4) begin
            for (int j = 0; j < 5; j++) begin
               fixed_errs = digest_queue.size() - 5 + j;
               if (digest_queue[fixed_errs].digest_word !==
                   (i == 0 ? EMPTY_DIGEST[j] : ABC_DIGEST[j]))
                  report_mismatch("known digest", digest_queue[fixed_errs].digest_word,
                                  i == 0 ? EMPTY_DIGEST[j] : ABC_DIGEST[j]);
            end
         end
      end
      // padding boundaries: 55, 56 and 64-byte messages
      send_message(55, 1'b0);
      send_message(55, 1'b1);
      send_message(64, 1'b0);

      // pause until the engine has drained everything
      wait_drained();
      repeat (200) @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
         recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
         for (int m = 0; m < 4; m++)
            send_message(($urandom_range(3) == 0) ? $urandom_range(50, 70)
                                                  : $urandom_range(0, 12),
                         1'($urandom));
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (errors == 0 && digest_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
